FILE: rtl/rsi_pkg.sv
// Shared types and constants for the 2D ray against segment intersection block.
// Used by every module under rtl; depends on nothing.
package rsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH_DEF    = 2;
	localparam int SQRT_STEPS    = 32;
	localparam int DIV_STEPS     = 32;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_MISS     = 2'd2,
		ST_ZERO_DIR = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [32:0] segx;
		logic signed [32:0] segy;
		logic signed [32:0] wx;
		logic signed [32:0] wy;
		logic               neg_x;
		logic               neg_y;
		logic [31:0]        mag_x;
		logic [31:0]        mag_y;
		logic [31:0]        len;
		logic               zero_dir;
	} geom_t;

	typedef struct packed {
		geom_t       g;
		logic [63:0] sq;
	} qent_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic               neg_x;
		logic               neg_y;
		logic [31:0]        qx;
		logic [31:0]        qy;
		logic               zero_dir;
	} ray_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic               neg_x;
		logic               neg_y;
		logic [31:0]        qx;
		logic [31:0]        qy;
		status_t            status;
	} pt_t;

endpackage

FILE: rtl/rsi_front.sv
// Front end: takes transactions, forms offsets, magnitudes and squared lengths.
// Flags a zero direction. Depends on rsi_pkg.
module rsi_front import rsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] seg_start_x,
	input  logic signed [31:0] seg_start_y,
	input  logic signed [31:0] seg_end_x,
	input  logic signed [31:0] seg_end_y,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic [31:0]        ray_length,
	input  logic               q_full,
	output logic               push,
	output qent_t              push_data
);

	logic        stall;
	logic        v_s1, v_s2;
	geom_t       g_s1, g_s2;
	logic [63:0] sqx_s2, sqy_s2;
	geom_t       g_in;

	always_comb begin
		stall     = v_s2 && q_full;
		busy      = stall;
		push      = v_s2 && !q_full;
		push_data = '{g: g_s2, sq: sqx_s2 + sqy_s2};
	end

	always_comb begin
		g_in.ox       = origin_x;
		g_in.oy       = origin_y;
		g_in.segx     = {seg_end_x[31], seg_end_x} - {seg_start_x[31], seg_start_x};
		g_in.segy     = {seg_end_y[31], seg_end_y} - {seg_start_y[31], seg_start_y};
		g_in.wx       = {seg_start_x[31], seg_start_x} - {origin_x[31], origin_x};
		g_in.wy       = {seg_start_y[31], seg_start_y} - {origin_y[31], origin_y};
		g_in.neg_x    = dir_x[31];
		g_in.neg_y    = dir_y[31];
		g_in.mag_x    = dir_x[31] ? 32'(-dir_x) : 32'(dir_x);
		g_in.mag_y    = dir_y[31] ? 32'(-dir_y) : 32'(dir_y);
		g_in.len      = ray_length;
		g_in.zero_dir = (dir_x == 32'sd0) && (dir_y == 32'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			if (start) begin
				g_s1 <= g_in;
			end
			g_s2   <= g_s1;
			sqx_s2 <= g_s1.mag_x * g_s1.mag_x;
			sqy_s2 <= g_s1.mag_y * g_s1.mag_y;
		end
	end

endmodule

FILE: rtl/rsi_queue.sv
// Short queue between the front end and the back end.
// Register array with head and tail pointers. Depends on rsi_pkg.
module rsi_queue import rsi_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	input  logic  pop,
	output logic  full,
	output logic  valid,
	output qent_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	always_comb begin
		full   = (cnt_q == CW'(DEPTH));
		valid  = (cnt_q != '0);
		head   = mem_q[rd_q];
		do_pop = pop && valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/rsi_back.sv
// Back end: square root, direction scaling, cross products, hit test,
// fraction division and hit point. One step per stage. Depends on rsi_pkg.
module rsi_back import rsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  qent_t              in_data,
	output logic               pop,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y
);

	localparam int TQW = FRAC_BITS + 1;
	localparam int MW  = 32 + TQW;

	assign pop = in_valid;

	// square root
	logic        sq_v    [SQRT_STEPS+1];
	geom_t       sq_g    [SQRT_STEPS+1];
	logic [63:0] sq_rem  [SQRT_STEPS+1];
	logic [63:0] sq_root [SQRT_STEPS+1];

	always_comb begin
		sq_v[0]    = in_valid;
		sq_g[0]    = in_data.g;
		sq_rem[0]  = in_data.sq;
		sq_root[0] = '0;
	end

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [64:0] BIT = 65'd1 << (62 - 2 * i);
		logic [64:0] trial;
		logic        ge;

		always_comb begin
			trial = {1'b0, sq_root[i]} + BIT;
			ge    = ({1'b0, sq_rem[i]} >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i+1] <= 1'b0;
			end else begin
				sq_v[i+1] <= sq_v[i];
			end
		end

		always_ff @(posedge clk) begin
			sq_g[i+1] <= sq_g[i];
			if (ge) begin
				sq_rem[i+1]  <= sq_rem[i] - trial[63:0];
				sq_root[i+1] <= (sq_root[i] >> 1) + BIT[63:0];
			end else begin
				sq_rem[i+1]  <= sq_rem[i];
				sq_root[i+1] <= sq_root[i] >> 1;
			end
		end
	end

	// magnitude times length
	logic        v_s1;
	geom_t       g_s1;
	logic [31:0] n_s1;
	logic [63:0] px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= sq_v[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		g_s1  <= sq_g[SQRT_STEPS];
		n_s1  <= sq_root[SQRT_STEPS][31:0];
		px_s1 <= sq_g[SQRT_STEPS].mag_x * sq_g[SQRT_STEPS].len;
		py_s1 <= sq_g[SQRT_STEPS].mag_y * sq_g[SQRT_STEPS].len;
	end

	// divide by the direction length
	logic        dv_v   [DIV_STEPS+1];
	geom_t       dv_g   [DIV_STEPS+1];
	logic [31:0] dv_n   [DIV_STEPS+1];
	logic [31:0] dv_rx  [DIV_STEPS+1];
	logic [31:0] dv_lx  [DIV_STEPS+1];
	logic [31:0] dv_ry  [DIV_STEPS+1];
	logic [31:0] dv_ly  [DIV_STEPS+1];

	always_comb begin
		dv_v[0]  = v_s1;
		dv_g[0]  = g_s1;
		dv_n[0]  = n_s1;
		dv_rx[0] = px_s1[63:32];
		dv_lx[0] = px_s1[31:0];
		dv_ry[0] = py_s1[63:32];
		dv_ly[0] = py_s1[31:0];
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [32:0] tx, ty;
		logic        gx, gy;

		always_comb begin
			tx = {dv_rx[k], dv_lx[k][31]};
			ty = {dv_ry[k], dv_ly[k][31]};
			gx = (tx >= {1'b0, dv_n[k]});
			gy = (ty >= {1'b0, dv_n[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_g[k+1]  <= dv_g[k];
			dv_n[k+1]  <= dv_n[k];
			dv_rx[k+1] <= gx ? 32'(tx - {1'b0, dv_n[k]}) : tx[31:0];
			dv_ry[k+1] <= gy ? 32'(ty - {1'b0, dv_n[k]}) : ty[31:0];
			dv_lx[k+1] <= {dv_lx[k][30:0], gx};
			dv_ly[k+1] <= {dv_ly[k][30:0], gy};
		end
	end

	// cross product terms
	geom_t              gd;
	logic signed [32:0] rx, ry;
	logic               v_s2;
	ray_t               r_s2;
	logic signed [65:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;

	always_comb begin
		gd = dv_g[DIV_STEPS];
		rx = gd.neg_x ? -$signed({1'b0, dv_lx[DIV_STEPS]}) : $signed({1'b0, dv_lx[DIV_STEPS]});
		ry = gd.neg_y ? -$signed({1'b0, dv_ly[DIV_STEPS]}) : $signed({1'b0, dv_ly[DIV_STEPS]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= dv_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		r_s2  <= '{ox: gd.ox, oy: gd.oy, neg_x: gd.neg_x, neg_y: gd.neg_y,
			qx: dv_lx[DIV_STEPS], qy: dv_ly[DIV_STEPS], zero_dir: gd.zero_dir};
		p1_s2 <= rx * gd.segy;
		p2_s2 <= ry * gd.segx;
		p3_s2 <= gd.wx * gd.segy;
		p4_s2 <= gd.wy * gd.segx;
		p5_s2 <= gd.wx * ry;
		p6_s2 <= gd.wy * rx;
	end

	// differences
	logic               v_s3;
	ray_t               r_s3;
	logic signed [66:0] d_s3, t_s3, u_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s3 <= r_s2;
		d_s3 <= {p1_s2[65], p1_s2} - {p2_s2[65], p2_s2};
		t_s3 <= {p3_s2[65], p3_s2} - {p4_s2[65], p4_s2};
		u_s3 <= {p5_s2[65], p5_s2} - {p6_s2[65], p6_s2};
	end

	// classify
	logic signed [66:0] dm, tm, um;
	status_t            st;
	logic               v_s4;
	pt_t                p_s4;
	logic [66:0]        dm_s4, tm_s4;

	always_comb begin
		dm = d_s3[66] ? -d_s3 : d_s3;
		tm = d_s3[66] ? -t_s3 : t_s3;
		um = d_s3[66] ? -u_s3 : u_s3;
		if (r_s3.zero_dir) begin
			st = ST_ZERO_DIR;
		end else if (d_s3 == '0) begin
			st = ST_PARALLEL;
		end else if (tm[66] || (tm > dm) || um[66] || (um > dm)) begin
			st = ST_MISS;
		end else begin
			st = ST_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s4  <= '{ox: r_s3.ox, oy: r_s3.oy, neg_x: r_s3.neg_x, neg_y: r_s3.neg_y,
			qx: r_s3.qx, qy: r_s3.qy, status: st};
		dm_s4 <= dm;
		tm_s4 <= tm;
	end

	// fraction of the ray
	logic           tq_v   [TQW+1];
	pt_t            tq_p   [TQW+1];
	logic [66:0]    tq_d   [TQW+1];
	logic [67:0]    tq_rem [TQW+1];
	logic [TQW-1:0] tq_q   [TQW+1];

	always_comb begin
		tq_v[0]   = v_s4;
		tq_p[0]   = p_s4;
		tq_d[0]   = dm_s4;
		tq_rem[0] = {1'b0, tm_s4};
		tq_q[0]   = '0;
	end

	for (genvar j = 0; j < TQW; j++) begin : g_frac
		logic [67:0] r2;
		logic        ge;

		always_comb begin
			r2 = (j == 0) ? tq_rem[j] : (tq_rem[j] << 1);
			ge = (r2 >= {1'b0, tq_d[j]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tq_v[j+1] <= 1'b0;
			end else begin
				tq_v[j+1] <= tq_v[j];
			end
		end

		always_ff @(posedge clk) begin
			tq_p[j+1]   <= tq_p[j];
			tq_d[j+1]   <= tq_d[j];
			tq_rem[j+1] <= ge ? r2 - {1'b0, tq_d[j]} : r2;
			tq_q[j+1]   <= {tq_q[j][TQW-2:0], ge};
		end
	end

	// offset along the ray
	logic          v_s5;
	pt_t           p_s5;
	logic [MW-1:0] mx_s5, my_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= tq_v[TQW];
		end
	end

	always_ff @(posedge clk) begin
		p_s5  <= tq_p[TQW];
		mx_s5 <= tq_p[TQW].qx * tq_q[TQW];
		my_s5 <= tq_p[TQW].qy * tq_q[TQW];
	end

	// add to origin, saturate
	function automatic logic signed [31:0] sat_add(logic signed [31:0] o, logic neg,
		logic [32:0] m);
		logic signed [34:0] s;
		s = neg ? ({{3{o[31]}}, o} - {2'b00, m}) : ({{3{o[31]}}, o} + {2'b00, m});
		if (!s[34] && (s[33:31] != 3'b000)) begin
			return 32'sh7FFF_FFFF;
		end else if (s[34] && (s[33:31] != 3'b111)) begin
			return 32'sh8000_0000;
		end
		return s[31:0];
	endfunction

	logic               done_q;
	status_t            status_q;
	logic signed [31:0] hx_q, hy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= p_s5.status;
		if (p_s5.status == ST_HIT) begin
			hx_q <= sat_add(p_s5.ox, p_s5.neg_x, mx_s5[FRAC_BITS +: 33]);
			hy_q <= sat_add(p_s5.oy, p_s5.neg_y, my_s5[FRAC_BITS +: 33]);
		end else begin
			hx_q <= '0;
			hy_q <= '0;
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign hit_x  = hx_q;
	assign hit_y  = hy_q;

endmodule

FILE: rtl/ray_segment_intersect_2d.sv
// Top level of the 2D ray against segment intersection block.
// Joins rsi_front, rsi_queue and rsi_back. Depends on rsi_pkg.
//
//   channel   handshake       fields
//   input     start / busy    origin_*, seg_start_*, seg_end_*, dir_*, ray_length
//   result    done strobe     status, hit_x, hit_y
//
// One transaction enters per cycle while busy is low; each result passes the
// 32-step square root, the 32-step length divider and the
// FRAC_BITS + 1 step fraction divider, all pipelined one step a stage.
// Reset clears only valid bits and queue pointers; a transaction can enter at once.
// busy rises only if the queue fills; the receiver cannot stall.
module ray_segment_intersect_2d import rsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int QDEPTH    = QDEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] seg_start_x,
	input  logic signed [31:0] seg_start_y,
	input  logic signed [31:0] seg_end_x,
	input  logic signed [31:0] seg_end_y,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic [31:0]        ray_length,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y
);

	logic  q_full, q_valid, q_pop, push;
	qent_t push_data, q_head;

	rsi_front u_front (
		.clk, .arst_n, .start, .busy,
		.origin_x, .origin_y, .seg_start_x, .seg_start_y,
		.seg_end_x, .seg_end_y, .dir_x, .dir_y, .ray_length,
		.q_full, .push, .push_data
	);

	rsi_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n, .push, .push_data,
		.pop(q_pop), .full(q_full), .valid(q_valid), .head(q_head)
	);

	rsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_data(q_head), .pop(q_pop),
		.done, .status, .hit_x, .hit_y
	);

endmodule

FILE: rtl/rsi_checker.sv
// Port-level checks for ray_segment_intersect_2d, attached by bind.
// Depends on rsi_pkg.
module rsi_checker import rsi_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic signed [31:0] hit_x,
	input logic signed [31:0] hit_y
);

	logic [7:0] outst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			outst_q <= outst_q + 8'(start && !busy) - 8'(done);
		end
	end

	a_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_HIT)) |-> ((hit_x == 32'sd0) && (hit_y == 32'sd0)))
		else $error("point not zero without a hit");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (outst_q != 8'd0))
		else $error("result without an outstanding transaction");

	a_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("queue filled although the back end drains every cycle");

endmodule

bind ray_segment_intersect_2d rsi_checker u_rsi_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .status(status), .hit_x(hit_x), .hit_y(hit_y)
);
